### hdl/i2c_master_byte_engine_defines.svh
// Assertion macros shared by the files that check the byte engine.
// Every check samples on the rising edge of clk and is off during reset.
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// The condition must hold in the same cycle as the trigger.
`define I2CM_ASSERT_SAME(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// The condition must hold in the cycle after the trigger.
`define I2CM_ASSERT_NEXT(lbl, trig, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

### hdl/i2cm_pkg.sv
`timescale 1ns / 1ps

package i2cm_pkg;

    // Byte framing.
    localparam int BITS_PER_BYTE = 8;
    localparam int BIT_CNT_W     = 4;
    localparam logic [BIT_CNT_W-1:0] BIT_CNT_LAST = BIT_CNT_W'(BITS_PER_BYTE);

    // Queue between the front and the back.
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    // Input kind codes.
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_STOP  = 3'd2;
    localparam logic [2:0] KIND_WRITE = 3'd3;
    localparam logic [2:0] KIND_READ  = 3'd4;

    // Operation carried by a queued tick.
    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_START = 3'd1,
        OP_STOP  = 3'd2,
        OP_WRITE = 3'd3,
        OP_READ  = 3'd4
    } op_t;

    // Step within the running sequence.
    typedef enum logic [7:0] {
        PH_IDLE = 8'b0000_0001,
        PH_1    = 8'b0000_0010,
        PH_2    = 8'b0000_0100,
        PH_3    = 8'b0000_1000,
        PH_4    = 8'b0001_0000,
        PH_5    = 8'b0010_0000,
        PH_6    = 8'b0100_0000,
        PH_7    = 8'b1000_0000
    } phase_t;

    // One classified tick as it waits in the queue.
    typedef struct packed {
        op_t        op;
        logic [7:0] data;
        logic       last;
        logic       sda;
    } item_t;

    // One result of the sequencer.
    typedef struct packed {
        logic       scl;
        logic       sda;
        logic       busy;
        logic       done;
        logic       ack;
        logic [7:0] rbyte;
    } result_t;

endpackage

### hdl/i2cm_front.sv
`timescale 1ns / 1ps

module i2cm_front
(
    input  logic             [2:0] kind,
    input  logic             [7:0] data_byte,
    input  logic                   last_byte,
    input  logic                   sda_in,
    output i2cm_pkg::item_t        item
);

    // Map the raw kind to an operation; unknown codes become plain ticks.
    always_comb
    begin
        item.data = data_byte;
        item.last = last_byte;
        item.sda  = sda_in;
        unique case (kind)
            i2cm_pkg::KIND_START: item.op = i2cm_pkg::OP_START;
            i2cm_pkg::KIND_STOP:  item.op = i2cm_pkg::OP_STOP;
            i2cm_pkg::KIND_WRITE: item.op = i2cm_pkg::OP_WRITE;
            i2cm_pkg::KIND_READ:  item.op = i2cm_pkg::OP_READ;
            default:              item.op = i2cm_pkg::OP_NONE;
        endcase
    end

endmodule

### hdl/i2cm_fifo.sv
`timescale 1ns / 1ps

module i2cm_fifo
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  i2cm_pkg::item_t        push_item,
    output logic                   full,
    input  logic                   pop,
    output logic                   not_empty,
    output i2cm_pkg::item_t        pop_item
);

    i2cm_pkg::item_t                    entry_reg [i2cm_pkg::FIFO_DEPTH];
    logic [i2cm_pkg::FIFO_PTR_W-1:0]    wr_ptr_reg;
    logic [i2cm_pkg::FIFO_PTR_W-1:0]    wr_ptr_next;
    logic [i2cm_pkg::FIFO_PTR_W-1:0]    rd_ptr_reg;
    logic [i2cm_pkg::FIFO_PTR_W-1:0]    rd_ptr_next;
    logic [i2cm_pkg::FIFO_CNT_W-1:0]    count_reg;
    logic [i2cm_pkg::FIFO_CNT_W-1:0]    count_next;
    logic                               do_push;
    logic                               do_pop;

    // Status flags.
    assign full      = (count_reg == i2cm_pkg::FIFO_CNT_W'(i2cm_pkg::FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    assign do_push = push && !full;
    assign do_pop  = pop && not_empty;

    // Pointer and occupancy update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

### hdl/i2cm_back.sv
`timescale 1ns / 1ps

module i2cm_back
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    input  i2cm_pkg::item_t        item,
    output logic                   item_pop,
    output logic                   res_valid,
    input  logic                   res_ready,
    output i2cm_pkg::result_t      res
);

    i2cm_pkg::phase_t                   phase_reg;
    i2cm_pkg::phase_t                   phase_next;
    i2cm_pkg::op_t                      op_reg;
    i2cm_pkg::op_t                      op_next;
    logic [i2cm_pkg::BIT_CNT_W-1:0]     bit_count_reg;
    logic [i2cm_pkg::BIT_CNT_W-1:0]     bit_count_next;
    logic [i2cm_pkg::BIT_CNT_W-1:0]     bit_inc;
    logic [7:0]                         shift_reg;
    logic [7:0]                         shift_next;
    logic                               nack_reg;
    logic                               nack_next;
    logic                               scl_reg;
    logic                               scl_next;
    logic                               sda_reg;
    logic                               sda_next;
    logic                               ack_reg;
    logic                               ack_next;
    logic                               busy;
    logic                               done;
    logic [7:0]                         rbyte;
    logic                               res_valid_reg;
    i2cm_pkg::result_t                  res_reg;

    // Take a tick whenever the result register is free or being drained.
    assign item_pop  = item_valid && (!res_valid_reg || res_ready);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;
    assign bit_inc   = bit_count_reg + 1'b1;

    // One line action per tick.
    always_comb
    begin
        phase_next     = phase_reg;
        op_next        = op_reg;
        bit_count_next = bit_count_reg;
        shift_next     = shift_reg;
        nack_next      = nack_reg;
        scl_next       = scl_reg;
        sda_next       = sda_reg;
        ack_next       = ack_reg;
        busy           = 1'b0;
        done           = 1'b0;
        rbyte          = '0;

        if (phase_reg == i2cm_pkg::PH_IDLE)
        begin
            // A command starts here and drives SCL low at once.
            if (item.op != i2cm_pkg::OP_NONE)
            begin
                op_next    = item.op;
                scl_next   = 1'b0;
                phase_next = i2cm_pkg::PH_1;
                busy       = 1'b1;
                if (item.op == i2cm_pkg::OP_WRITE)
                begin
                    shift_next     = item.data;
                    bit_count_next = '0;
                end
                else if (item.op == i2cm_pkg::OP_READ)
                begin
                    shift_next     = '0;
                    bit_count_next = '0;
                    nack_next      = item.last;
                end
            end
        end
        else
        begin
            busy = 1'b1;
            unique case (op_reg)
                // Start and stop conditions.
                i2cm_pkg::OP_START, i2cm_pkg::OP_STOP:
                begin
                    unique case (phase_reg)
                        i2cm_pkg::PH_1:
                        begin
                            sda_next   = (op_reg == i2cm_pkg::OP_START);
                            phase_next = i2cm_pkg::PH_2;
                        end
                        i2cm_pkg::PH_2:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cm_pkg::PH_3;
                        end
                        i2cm_pkg::PH_3:
                        begin
                            sda_next   = (op_reg == i2cm_pkg::OP_STOP);
                            done       = 1'b1;
                            phase_next = i2cm_pkg::PH_IDLE;
                            op_next    = i2cm_pkg::OP_NONE;
                        end
                        default:
                        begin
                            busy       = 1'b0;
                            phase_next = i2cm_pkg::PH_IDLE;
                            op_next    = i2cm_pkg::OP_NONE;
                        end
                    endcase
                end
                // Byte write, MSB first, then the acknowledge slot.
                i2cm_pkg::OP_WRITE:
                begin
                    unique case (phase_reg)
                        i2cm_pkg::PH_1:
                        begin
                            sda_next   = shift_reg[7];
                            phase_next = i2cm_pkg::PH_2;
                        end
                        i2cm_pkg::PH_2:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cm_pkg::PH_3;
                        end
                        i2cm_pkg::PH_3:
                        begin
                            scl_next       = 1'b0;
                            shift_next     = {shift_reg[6:0], 1'b0};
                            bit_count_next = bit_inc;
                            phase_next     = (bit_inc >= i2cm_pkg::BIT_CNT_LAST) ?
                                             i2cm_pkg::PH_4 : i2cm_pkg::PH_1;
                        end
                        i2cm_pkg::PH_4:
                        begin
                            sda_next   = 1'b1;
                            phase_next = i2cm_pkg::PH_5;
                        end
                        i2cm_pkg::PH_5:
                        begin
                            scl_next   = 1'b1;
                            ack_next   = !item.sda;
                            phase_next = i2cm_pkg::PH_6;
                        end
                        i2cm_pkg::PH_6:
                        begin
                            scl_next   = 1'b0;
                            done       = 1'b1;
                            phase_next = i2cm_pkg::PH_IDLE;
                            op_next    = i2cm_pkg::OP_NONE;
                        end
                        default:
                        begin
                            busy       = 1'b0;
                            phase_next = i2cm_pkg::PH_IDLE;
                            op_next    = i2cm_pkg::OP_NONE;
                        end
                    endcase
                end
                // Byte read, MSB first, then ACK or NACK from the master.
                i2cm_pkg::OP_READ:
                begin
                    unique case (phase_reg)
                        i2cm_pkg::PH_1:
                        begin
                            sda_next   = 1'b1;
                            phase_next = i2cm_pkg::PH_2;
                        end
                        i2cm_pkg::PH_2:
                        begin
                            scl_next   = 1'b1;
                            shift_next = {shift_reg[6:0], item.sda};
                            phase_next = i2cm_pkg::PH_3;
                        end
                        i2cm_pkg::PH_3:
                        begin
                            scl_next       = 1'b0;
                            bit_count_next = bit_inc;
                            phase_next     = (bit_inc >= i2cm_pkg::BIT_CNT_LAST) ?
                                             i2cm_pkg::PH_4 : i2cm_pkg::PH_2;
                        end
                        i2cm_pkg::PH_4:
                        begin
                            sda_next   = nack_reg;
                            phase_next = i2cm_pkg::PH_5;
                        end
                        i2cm_pkg::PH_5:
                        begin
                            scl_next   = 1'b1;
                            phase_next = i2cm_pkg::PH_6;
                        end
                        i2cm_pkg::PH_6:
                        begin
                            scl_next = 1'b0;
                            if (nack_reg)
                            begin
                                done       = 1'b1;
                                rbyte      = shift_reg;
                                phase_next = i2cm_pkg::PH_IDLE;
                                op_next    = i2cm_pkg::OP_NONE;
                            end
                            else
                            begin
                                phase_next = i2cm_pkg::PH_7;
                            end
                        end
                        i2cm_pkg::PH_7:
                        begin
                            sda_next   = 1'b1;
                            done       = 1'b1;
                            rbyte      = shift_reg;
                            phase_next = i2cm_pkg::PH_IDLE;
                            op_next    = i2cm_pkg::OP_NONE;
                        end
                        default:
                        begin
                            busy       = 1'b0;
                            phase_next = i2cm_pkg::PH_IDLE;
                            op_next    = i2cm_pkg::OP_NONE;
                        end
                    endcase
                end
                default:
                begin
                    busy       = 1'b0;
                    phase_next = i2cm_pkg::PH_IDLE;
                    op_next    = i2cm_pkg::OP_NONE;
                end
            endcase
        end
    end

    // Sequencer state advances only on a taken tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= i2cm_pkg::PH_IDLE;
            op_reg        <= i2cm_pkg::OP_NONE;
            bit_count_reg <= '0;
            shift_reg     <= '0;
            nack_reg      <= 1'b0;
            scl_reg       <= 1'b1;
            sda_reg       <= 1'b1;
            ack_reg       <= 1'b0;
        end
        else if (item_pop)
        begin
            phase_reg     <= phase_next;
            op_reg        <= op_next;
            bit_count_reg <= bit_count_next;
            shift_reg     <= shift_next;
            nack_reg      <= nack_next;
            scl_reg       <= scl_next;
            sda_reg       <= sda_next;
            ack_reg       <= ack_next;
        end
    end

    // Result register valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (item_pop)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (item_pop)
        begin
            res_reg.scl   <= scl_next;
            res_reg.sda   <= sda_next;
            res_reg.busy  <= busy;
            res_reg.done  <= done;
            res_reg.ack   <= ack_next;
            res_reg.rbyte <= rbyte;
        end
    end

endmodule

### hdl/i2c_master_byte_engine.sv
`timescale 1ns / 1ps
// Channel  | Handshake           | Payload
// ---------+---------------------+-------------------------------------------------
// input    | in_valid, in_ready  | kind, data_byte, last_byte, sda_in
// output   | out_valid, out_ready| scl_out, sda_out, busy_res, done_res,
//          |                     | ack_received, read_byte
//
// One tick is taken per clock while in_ready is high and each tick gives exactly one result.
// A tick lands in a two-entry queue; the sequencer takes it once the result register is free
// or being drained, and that same edge loads its result into the output register.
// The sequencer's result register sets the rate: it frees every cycle out_ready is high.
// Reset is asynchronous and active low; the engine comes up idle, SCL high, SDA released.
// A stalled output holds the sequencer; the queue then fills and in_ready drops.
`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] kind,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       sda_in,
    output logic       out_valid,
    input  logic       out_ready,
    output logic       scl_out,
    output logic       sda_out,
    output logic       busy_res,
    output logic       done_res,
    output logic       ack_received,
    output logic [7:0] read_byte
);

    i2cm_pkg::item_t   front_item;
    i2cm_pkg::item_t   queue_item;
    i2cm_pkg::result_t result;
    logic              queue_full;
    logic              queue_valid;
    logic              queue_pop;

    // Classify incoming ticks.
    i2cm_front u_front
    (
        .kind      (kind),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .sda_in    (sda_in),
        .item      (front_item)
    );

    // Decoupling queue.
    i2cm_fifo u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_item  (queue_item)
    );

    assign in_ready = !queue_full;

    // Bus sequencer and result register.
    i2cm_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (queue_valid),
        .item       (queue_item),
        .item_pop   (queue_pop),
        .res_valid  (out_valid),
        .res_ready  (out_ready),
        .res        (result)
    );

    assign scl_out      = result.scl;
    assign sda_out      = result.sda;
    assign busy_res     = result.busy;
    assign done_res     = result.done;
    assign ack_received = result.ack;
    assign read_byte    = result.rbyte;

    // A finishing tick is always part of a running sequence.
    `I2CM_ASSERT_SAME(a_done_busy, out_valid && done_res, busy_res, "done without busy")
    // The received byte shows only on the finishing tick.
    `I2CM_ASSERT_SAME(a_rbyte_done, out_valid && !done_res, read_byte == 8'd0,
        "read byte outside done")
    // A queued tick with a free result register yields a result next cycle.
    `I2CM_ASSERT_NEXT(a_queue_drain, queue_valid && (!out_valid || out_ready), out_valid,
        "queued tick not taken")

endmodule

### bench/i2c_master_byte_engine_checker.sv
`timescale 1ns / 1ps

module i2c_master_byte_engine_checker
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [2:0] kind,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       sda_in,
    input  logic       out_valid,
    input  logic       out_ready,
    input  logic       scl_out,
    input  logic       sda_out,
    input  logic       busy_res,
    input  logic       done_res,
    input  logic       ack_received,
    input  logic [7:0] read_byte,
    output int         errors,
    output int         outstanding
);

    // Bus engine state as the sequencer should hold it.
    phase_t     bus_phase;
    op_t        bus_op;
    logic [3:0] bit_cnt;
    logic [7:0] shift_reg;
    logic       nack_pending;
    logic       scl_level;
    logic       sda_level;
    logic       ack_level;

    // Line levels and flags expected for each accepted tick, oldest first.
    result_t    expected_lines[$];

    // Return the engine to idle at the end of a command.
    task automatic go_idle();
        bus_phase = PH_IDLE;
        bus_op    = OP_NONE;
    endtask

    // Advance the engine by one bus phase tick and give the resulting line state.
    task automatic advance_bus(input logic [2:0] k, input logic [7:0] d, input logic l,
                               input logic s, output result_t r);
        logic       busy;
        logic       done;
        logic [7:0] rbyte;
        busy  = 1'b0;
        done  = 1'b0;
        rbyte = 8'h00;
        if (bus_phase == PH_IDLE)
        begin
            // Commands are taken only while idle; the first line action happens now.
            if (k >= KIND_START && k <= KIND_READ)
            begin
                bus_op    = op_t'(k);
                scl_level = 1'b0;
                bus_phase = PH_1;
                busy      = 1'b1;
                if (k == KIND_WRITE)
                begin
                    shift_reg = d;
                    bit_cnt   = 4'd0;
                end
                else if (k == KIND_READ)
                begin
                    shift_reg    = 8'h00;
                    bit_cnt      = 4'd0;
                    nack_pending = l;
                end
            end
        end
        else
        begin
            busy = 1'b1;
            case (bus_op)
                OP_START, OP_STOP:
                begin
                    case (bus_phase)
                        PH_1:
                        begin
                            sda_level = (bus_op == OP_START);
                            bus_phase = PH_2;
                        end
                        PH_2:
                        begin
                            scl_level = 1'b1;
                            bus_phase = PH_3;
                        end
                        PH_3:
                        begin
                            sda_level = (bus_op == OP_STOP);
                            done      = 1'b1;
                            go_idle();
                        end
                        default:
                        begin
                            busy = 1'b0;
                            go_idle();
                        end
                    endcase
                end
                OP_WRITE:
                begin
                    case (bus_phase)
                        PH_1:
                        begin
                            sda_level = shift_reg[7];
                            bus_phase = PH_2;
                        end
                        PH_2:
                        begin
                            scl_level = 1'b1;
                            bus_phase = PH_3;
                        end
                        PH_3:
                        begin
                            scl_level = 1'b0;
                            shift_reg = {shift_reg[6:0], 1'b0};
                            bit_cnt   = bit_cnt + 4'd1;
                            bus_phase = (bit_cnt >= BITS_PER_BYTE) ? PH_4 : PH_1;
                        end
                        PH_4:
                        begin
                            sda_level = 1'b1;
                            bus_phase = PH_5;
                        end
                        PH_5:
                        begin
                            // The slave acknowledges by pulling SDA low.
                            scl_level = 1'b1;
                            ack_level = !s;
                            bus_phase = PH_6;
                        end
                        PH_6:
                        begin
                            scl_level = 1'b0;
                            done      = 1'b1;
                            go_idle();
                        end
                        default:
                        begin
                            busy = 1'b0;
                            go_idle();
                        end
                    endcase
                end
                OP_READ:
                begin
                    case (bus_phase)
                        PH_1:
                        begin
                            sda_level = 1'b1;
                            bus_phase = PH_2;
                        end
                        PH_2:
                        begin
                            scl_level = 1'b1;
                            shift_reg = {shift_reg[6:0], s};
                            bus_phase = PH_3;
                        end
                        PH_3:
                        begin
                            scl_level = 1'b0;
                            bit_cnt   = bit_cnt + 4'd1;
                            bus_phase = (bit_cnt >= BITS_PER_BYTE) ? PH_4 : PH_2;
                        end
                        PH_4:
                        begin
                            sda_level = nack_pending;
                            bus_phase = PH_5;
                        end
                        PH_5:
                        begin
                            scl_level = 1'b1;
                            bus_phase = PH_6;
                        end
                        PH_6:
                        begin
                            scl_level = 1'b0;
                            if (nack_pending)
                            begin
                                done  = 1'b1;
                                rbyte = shift_reg;
                                go_idle();
                            end
                            else
                            begin
                                bus_phase = PH_7;
                            end
                        end
                        PH_7:
                        begin
                            // After an ACK the master lets go of SDA again.
                            sda_level = 1'b1;
                            done      = 1'b1;
                            rbyte     = shift_reg;
                            go_idle();
                        end
                        default:
                        begin
                            busy = 1'b0;
                            go_idle();
                        end
                    endcase
                end
                default:
                begin
                    busy = 1'b0;
                    go_idle();
                end
            endcase
        end
        r.scl   = scl_level;
        r.sda   = sda_level;
        r.busy  = busy;
        r.done  = done;
        r.ack   = ack_level;
        r.rbyte = rbyte;
    endtask

    // Compare one output field and report a difference.
    task automatic check_field(input string fname, input int want, input int got);
        if (want != got)
        begin
            errors++;
            $display("%0t ns: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // Predict on every input transaction and compare on every output transaction.
    always @(posedge clk or negedge rst_n)
    begin : monitor
        result_t predicted;
        result_t want;
        if (!rst_n)
        begin
            bus_phase    = PH_IDLE;
            bus_op       = OP_NONE;
            bit_cnt      = 4'd0;
            shift_reg    = 8'h00;
            nack_pending = 1'b0;
            scl_level    = 1'b1;
            sda_level    = 1'b1;
            ack_level    = 1'b0;
            expected_lines.delete();
            errors       = 0;
            outstanding  = 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_bus(kind, data_byte, last_byte, sda_in, predicted);
                expected_lines.push_back(predicted);
            end
            if (out_valid && out_ready)
            begin
                if (expected_lines.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: output transaction with nothing expected", $time);
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("scl_out", want.scl, scl_out);
                    check_field("sda_out", want.sda, sda_out);
                    check_field("busy_res", want.busy, busy_res);
                    check_field("done_res", want.done, done_res);
                    check_field("ack_received", want.ack, ack_received);
                    check_field("read_byte", want.rbyte, read_byte);
                end
            end
            outstanding = expected_lines.size();
        end
    end

endmodule

### bench/i2c_master_byte_engine_tb.sv
`timescale 1ns / 1ps

module i2c_master_byte_engine_tb;

    import i2cm_pkg::*;

    // Kind codes outside the command set; the engine treats them as plain ticks.
    localparam logic [2:0] KIND_RSVD_FIRST = 3'd5;
    localparam logic [2:0] KIND_RSVD_LAST  = 3'd7;

    // How SDA is sampled during a sequence.
    localparam int SDA_RANDOM = 0;
    localparam int SDA_LOW    = 1;
    localparam int SDA_HIGH   = 2;

    localparam int RANDOM_TICKS = 630;
    localparam int IDLE_SPAN    = 250;
    localparam int PRESSURE_AT  = 560;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 16;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       in_valid     = 1'b0;
    logic       in_ready;
    logic [2:0] kind         = KIND_TICK;
    logic [7:0] data_byte    = 8'h00;
    logic       last_byte    = 1'b0;
    logic       sda_in       = 1'b1;
    logic       out_valid;
    logic       out_ready    = 1'b0;
    logic       scl_out;
    logic       sda_out;
    logic       busy_res;
    logic       done_res;
    logic       ack_received;
    logic [7:0] read_byte;

    int sent_count        = 0;
    int sender_idle_pct   = 8;
    int receiver_idle_pct = 68;
    int errors;
    int outstanding;

    i2c_master_byte_engine u_dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .ack_received (ack_received),
        .read_byte    (read_byte)
    );

    i2c_master_byte_engine_checker u_checker
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .sda_in       (sda_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .scl_out      (scl_out),
        .sda_out      (sda_out),
        .busy_res     (busy_res),
        .done_res     (done_res),
        .ack_received (ack_received),
        .read_byte    (read_byte),
        .errors       (errors),
        .outstanding  (outstanding)
    );

    // 100 MHz clock.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reset is held at the start of the run only.
    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Hard stop in case the engine hangs.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // Output side: random back-pressure plus one long hold-off that fills the queue.
    initial
    begin : receiver
        int  hold_left;
        bit  held;
        hold_left = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && sent_count >= PRESSURE_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= receiver_idle_pct);
            end
        end
    end

    // Byte values with the extremes favored.
    function automatic logic [7:0] pick_byte();
        int sel;
        sel = $urandom_range(7);
        if (sel == 0)
            return 8'h00;
        if (sel == 1)
            return 8'hFF;
        return 8'($urandom_range(255));
    endfunction

    function automatic logic pick_sda(input int mode);
        if (mode == SDA_LOW)
            return 1'b0;
        if (mode == SDA_HIGH)
            return 1'b1;
        return 1'($urandom_range(1));
    endfunction

    // Offer one tick and wait for its input transaction.
    task automatic send_tick(input logic [2:0] k, input logic [7:0] d, input logic l,
                             input logic s);
        if (sent_count < IDLE_SPAN)
        begin
            sender_idle_pct   = 8;
            receiver_idle_pct = 68;
        end
        else if (sent_count < 2 * IDLE_SPAN)
        begin
            sender_idle_pct   = 68;
            receiver_idle_pct = 8;
        end
        else
        begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
        end
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        data_byte <= d;
        last_byte <= l;
        sda_in    <= s;
        do
            @(posedge clk);
        while (!in_ready);
        sent_count++;
    endtask

    // One command followed by the ticks that carry it to completion.
    // Now and then a stray command arrives mid-sequence and must be ignored.
    task automatic run_command(input logic [2:0] k, input logic [7:0] d, input logic l,
                               input int sda_mode, input int cut);
        int follow;
        int n;
        logic [2:0] fk;
        case (k)
            KIND_WRITE: follow = 3 * BITS_PER_BYTE + 3;
            KIND_READ:  follow = 2 * BITS_PER_BYTE + (l ? 4 : 5);
            default:    follow = 3;
        endcase
        follow = follow - cut;
        send_tick(k, d, l, pick_sda(sda_mode));
        for (n = 0; n < follow; n++)
        begin
            fk = KIND_TICK;
            if ($urandom_range(15) == 0)
                fk = 3'($urandom_range(KIND_START, KIND_RSVD_LAST));
            send_tick(fk, pick_byte(), 1'($urandom_range(1)), pick_sda(sda_mode));
        end
    endtask

    initial
    begin : stimulus
        int         base;
        int         sel;
        int         sda_mode;
        int         cut;
        logic [2:0] k;

        @(posedge rst_n);
        @(posedge clk);

        // Plain and unknown-kind ticks while idle.
        send_tick(KIND_TICK, 8'h00, 1'b0, 1'b0);
        for (k = KIND_RSVD_FIRST; k != KIND_TICK; k++)
            send_tick(k, 8'hFF, 1'b1, 1'b1);

        // Start condition with commands arriving while it runs.
        send_tick(KIND_START, 8'hA5, 1'b0, 1'b1);
        send_tick(KIND_WRITE, 8'hFF, 1'b1, 1'b0);
        send_tick(KIND_READ, 8'h00, 1'b0, 1'b1);
        send_tick(KIND_STOP, 8'h00, 1'b1, 1'b0);

        // Write of the top bit alone, acknowledged; read with NACK of all ones; stop.
        run_command(KIND_WRITE, 8'h80, 1'b0, SDA_LOW, 0);
        run_command(KIND_READ, 8'h00, 1'b1, SDA_HIGH, 0);
        run_command(KIND_STOP, 8'h00, 1'b0, SDA_RANDOM, 0);

        // Random traffic: mostly complete command sequences, some noise and short ones.
        base = sent_count;
        while (sent_count < base + RANDOM_TICKS)
        begin
            sel      = $urandom_range(99);
            sda_mode = $urandom_range(7);
            if (sda_mode > SDA_HIGH)
                sda_mode = SDA_RANDOM;
            cut = ($urandom_range(19) == 0) ? $urandom_range(1, 3) : 0;
            if (sel < 38)
                run_command(KIND_WRITE, pick_byte(), 1'($urandom_range(1)), sda_mode, cut);
            else if (sel < 64)
                run_command(KIND_READ, pick_byte(), 1'($urandom_range(1)), sda_mode, cut);
            else if (sel < 76)
                run_command(KIND_START, pick_byte(), 1'($urandom_range(1)), sda_mode, cut);
            else if (sel < 88)
                run_command(KIND_STOP, pick_byte(), 1'($urandom_range(1)), sda_mode, cut);
            else
            begin
                k = ($urandom_range(1) == 0) ? KIND_TICK
                                             : 3'($urandom_range(KIND_RSVD_FIRST, KIND_RSVD_LAST));
                send_tick(k, pick_byte(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            end
        end
        in_valid <= 1'b0;

        // Let every expected result come out, then watch for strays.
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);

        if (errors == 0 && outstanding == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
